/* hdl/cgev_pkg.sv */
`default_nettype none

package cgev_pkg;

   localparam int MAX_KEYS_DEFAULT = 8;
   localparam int TIME_WIDTH       = 32;
   localparam int POS_WIDTH        = 16;
   localparam int RGBA_WIDTH       = 32;
   localparam int SLOT_WIDTH       = 3;
   localparam int COUNT_WIDTH      = 4;
   localparam int FRAC_WIDTH       = 17;
   localparam int REQ_DATA_WIDTH   = 88;

   typedef enum logic {
      OP_EVALUATE = 1'b0,
      OP_LOAD     = 1'b1
   } op_type;

   typedef enum logic {
      CSR_KEY_COUNT   = 1'b0,
      CSR_SPAN_LENGTH = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

/* hdl/color_gradient_evaluate_top.sv */
// channel   direction  tdata / data                          tuser / index
// req       in         time, key_slot, key_position, rgba   op
// rsp       out        rgba_out                              -
// csr       in         write data (32)                       register index (1)
// a req transaction passes the input stage, norm divider, lookup, frac divider and mix to rsp
// one req transaction per cycle while rsp is not stalled; the two 16/17-stage divider pipelines set the depth
// reset clears all valid bits and both registers; the key table is not cleared
// every stage advances together, held while rsp is valid and not taken
`default_nettype none

module color_gradient_evaluate_top
   import cgev_pkg::*;
#(
   parameter int MAX_KEYS = MAX_KEYS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,  // sample_time, key_slot, key_position, key_rgba
   input  wire logic                      req_tuser,  // op
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RGBA_WIDTH-1:0]          rsp_tdata,  // rgba_out
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic                      csr_index,
   input  wire logic [31:0]               csr_data
);

   localparam int SIDE1_W = 1 + SLOT_WIDTH + POS_WIDTH + RGBA_WIDTH + 1 + POS_WIDTH;

   logic                   advance;
   logic [COUNT_WIDTH-1:0] key_count_ff;
   logic [TIME_WIDTH-1:0]  span_ff;

   logic                   a_vld_ff;
   logic                   a_op_ff;
   logic [TIME_WIDTH-1:0]  a_time_ff;
   logic [SLOT_WIDTH-1:0]  a_slot_ff;
   logic [POS_WIDTH-1:0]   a_pos_ff;
   logic [RGBA_WIDTH-1:0]  a_rgba_ff;

   logic                   t_pos;
   logic                   direct;
   logic [POS_WIDTH-1:0]   dtime;
   logic [16:0]            tclamp;
   logic [32:0]            sprod;
   logic [47:0]            nprod;

   logic                   d1_vld;
   logic [POS_WIDTH-1:0]   d1_quo;
   logic [SIDE1_W-1:0]     d1_side;
   logic                   d1_op;
   logic [SLOT_WIDTH-1:0]  d1_slot;
   logic [POS_WIDTH-1:0]   d1_pos;
   logic [RGBA_WIDTH-1:0]  d1_rgba;
   logic                   d1_direct;
   logic [POS_WIDTH-1:0]   d1_dtime;

   logic                   lk_vld;
   logic [POS_WIDTH-1:0]   lk_diff;
   logic [POS_WIDTH-1:0]   lk_span;
   logic [RGBA_WIDTH-1:0]  lk_a;
   logic [RGBA_WIDTH-1:0]  lk_b;

   logic                   d2_vld;
   logic [FRAC_WIDTH-1:0]  d2_quo;
   logic [2*RGBA_WIDTH-1:0] d2_side;

   logic                   out_vld;

   assign advance    = !out_vld || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
         span_ff      <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_COUNT:   key_count_ff <= csr_data[COUNT_WIDTH-1:0];
            CSR_SPAN_LENGTH: span_ff      <= csr_data;
            default:         span_ff      <= span_ff;
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (advance) begin
         a_vld_ff <= req_tvalid;
      end
      if (advance) begin
         a_op_ff   <= req_tuser;
         a_time_ff <= req_tdata[31:0];
         a_slot_ff <= req_tdata[34:32];
         a_pos_ff  <= req_tdata[50:35];
         a_rgba_ff <= req_tdata[82:51];
      end
   end

   // time normalization ahead of the divider
   always_comb begin
      t_pos  = !a_time_ff[31] && (a_time_ff != '0);
      tclamp = (a_time_ff > 32'h0001_0000) ? 17'h1_0000 : a_time_ff[16:0];
      sprod  = {tclamp, 16'h0} - {16'h0, tclamp};
      nprod  = {a_time_ff, 16'h0} - {16'h0, a_time_ff};
      direct = 1'b1;
      dtime  = '0;
      if (span_ff != '0) begin
         if (!t_pos) begin
            dtime = '0;
         end else if (a_time_ff >= span_ff) begin
            dtime = 16'hFFFF;
         end else begin
            direct = 1'b0;
         end
      end else if (t_pos) begin
         dtime = sprod[31:16];
      end
   end

   cgev_divpipe #(
      .QW (POS_WIDTH),
      .DW (TIME_WIDTH),
      .SW (SIDE1_W)
   ) u_norm_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (a_vld_ff),
      .in_rem    (nprod[47:16]),
      .in_bits   (nprod[15:0]),
      .in_div    (span_ff),
      .in_side   ({a_op_ff, a_slot_ff, a_pos_ff, a_rgba_ff, direct, dtime}),
      .out_valid (d1_vld),
      .out_quo   (d1_quo),
      .out_side  (d1_side)
   );

   assign {d1_op, d1_slot, d1_pos, d1_rgba, d1_direct, d1_dtime} = d1_side;

   cgev_lookup #(
      .MAX_KEYS (MAX_KEYS)
   ) u_lookup (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (d1_vld),
      .in_op      (d1_op),
      .in_slot    (d1_slot),
      .in_pos     (d1_pos),
      .in_rgba    (d1_rgba),
      .in_time    (d1_direct ? d1_dtime : d1_quo),
      .key_count  (key_count_ff),
      .out_valid  (lk_vld),
      .out_diff   (lk_diff),
      .out_span   (lk_span),
      .out_rgba_a (lk_a),
      .out_rgba_b (lk_b)
   );

   cgev_divpipe #(
      .QW (FRAC_WIDTH),
      .DW (POS_WIDTH),
      .SW (2*RGBA_WIDTH)
   ) u_frac_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (lk_vld),
      .in_rem    ({1'b0, lk_diff[POS_WIDTH-1:1]}),
      .in_bits   ({lk_diff[0], 16'h0}),
      .in_div    (lk_span),
      .in_side   ({lk_a, lk_b}),
      .out_valid (d2_vld),
      .out_quo   (d2_quo),
      .out_side  (d2_side)
   );

   cgev_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (d2_vld),
      .in_frac   (d2_quo),
      .in_rgba_a (d2_side[2*RGBA_WIDTH-1:RGBA_WIDTH]),
      .in_rgba_b (d2_side[RGBA_WIDTH-1:0]),
      .out_valid (out_vld),
      .out_rgba  (rsp_tdata)
   );

endmodule

`default_nettype wire

/* hdl/cgev_divpipe.sv */
`default_nettype none

module cgev_divpipe
   import cgev_pkg::*;
#(
   parameter int QW = 16,
   parameter int DW = 32,
   parameter int SW = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          in_valid,
   input  wire logic [DW-1:0] in_rem,
   input  wire logic [QW-1:0] in_bits,
   input  wire logic [DW-1:0] in_div,
   input  wire logic [SW-1:0] in_side,
   output logic               out_valid,
   output logic [QW-1:0]      out_quo,
   output logic [SW-1:0]      out_side
);

   logic          vld_ff  [0:QW];
   logic [DW-1:0] rem_ff  [0:QW];
   logic [QW-1:0] bits_ff [0:QW];
   logic [QW-1:0] quo_ff  [0:QW];
   logic [DW-1:0] div_ff  [0:QW];
   logic [SW-1:0] side_ff [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
      end
      if (advance) begin
         rem_ff[0]  <= in_rem;
         bits_ff[0] <= in_bits;
         quo_ff[0]  <= '0;
         div_ff[0]  <= in_div;
         side_ff[0] <= in_side;
      end
   end

   for (genvar g = 0; g < QW; g++) begin : g_stage
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[g], bits_ff[g][QW-1]};
         ge     = (trial >= {1'b0, div_ff[g]});
         rem_in = ge ? DW'(trial - {1'b0, div_ff[g]}) : trial[DW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[g+1] <= vld_ff[g];
         end
         if (advance) begin
            rem_ff[g+1]  <= rem_in;
            bits_ff[g+1] <= {bits_ff[g][QW-2:0], 1'b0};
            quo_ff[g+1]  <= {quo_ff[g][QW-2:0], ge};
            div_ff[g+1]  <= div_ff[g];
            side_ff[g+1] <= side_ff[g];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_quo   = quo_ff[QW];
   assign out_side  = side_ff[QW];

endmodule

`default_nettype wire

/* hdl/cgev_lookup.sv */
`default_nettype none

module cgev_lookup
   import cgev_pkg::*;
#(
   parameter int MAX_KEYS = MAX_KEYS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  wire logic                   in_op,
   input  wire logic [SLOT_WIDTH-1:0]  in_slot,
   input  wire logic [POS_WIDTH-1:0]   in_pos,
   input  wire logic [RGBA_WIDTH-1:0]  in_rgba,
   input  wire logic [POS_WIDTH-1:0]   in_time,
   input  wire logic [COUNT_WIDTH-1:0] key_count,
   output logic                        out_valid,
   output logic [POS_WIDTH-1:0]        out_diff,
   output logic [POS_WIDTH-1:0]        out_span,
   output logic [RGBA_WIDTH-1:0]       out_rgba_a,
   output logic [RGBA_WIDTH-1:0]       out_rgba_b
);

   localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int NW = $clog2(MAX_KEYS + 1);

   logic [POS_WIDTH-1:0]  pos_ff  [0:MAX_KEYS-1];
   logic [RGBA_WIDTH-1:0] rgba_ff [0:MAX_KEYS-1];

   logic                  valid_ff;
   logic [POS_WIDTH-1:0]  diff_ff, diff_in;
   logic [POS_WIDTH-1:0]  span_ff, span_in;
   logic [RGBA_WIDTH-1:0] rgba_a_ff, rgba_a_in;
   logic [RGBA_WIDTH-1:0] rgba_b_ff, rgba_b_in;

   logic [NW-1:0]        n;
   logic                 found;
   logic [IW-1:0]        idx;
   logic [IW-1:0]        prv;
   logic [IW-1:0]        last;
   logic [POS_WIDTH-1:0] cur_pos;
   logic [POS_WIDTH-1:0] prv_pos;

   always_comb begin
      n = (32'(key_count) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(key_count);
      found = 1'b0;
      idx   = '0;
      for (int i = 1; i < MAX_KEYS; i++) begin
         if (!found && (i < 32'(n)) && (in_time <= pos_ff[i])) begin
            found = 1'b1;
            idx   = IW'(i);
         end
      end
      prv     = idx - IW'(1);
      last    = IW'(32'(n) - 1);
      cur_pos = pos_ff[idx];
      prv_pos = pos_ff[prv];

      diff_in   = '0;
      span_in   = POS_WIDTH'(1);
      rgba_a_in = '0;
      rgba_b_in = '0;
      if (n == '0) begin
         rgba_a_in = '0;
         rgba_b_in = '0;
      end else if (n == NW'(1) || in_time < pos_ff[0]) begin
         rgba_a_in = rgba_ff[0];
         rgba_b_in = rgba_ff[0];
      end else if (!found) begin
         rgba_a_in = rgba_ff[last];
         rgba_b_in = rgba_ff[last];
      end else begin
         rgba_a_in = rgba_ff[prv];
         rgba_b_in = rgba_ff[idx];
         if (cur_pos > prv_pos && in_time > prv_pos) begin
            diff_in = in_time - prv_pos;
            span_in = cur_pos - prv_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid && in_op == OP_LOAD && 32'(in_slot) < MAX_KEYS) begin
         pos_ff[IW'(in_slot)]  <= in_pos;
         rgba_ff[IW'(in_slot)] <= in_rgba;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid && in_op == OP_EVALUATE;
      end
      if (advance) begin
         diff_ff   <= diff_in;
         span_ff   <= span_in;
         rgba_a_ff <= rgba_a_in;
         rgba_b_ff <= rgba_b_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_diff   = diff_ff;
   assign out_span   = span_ff;
   assign out_rgba_a = rgba_a_ff;
   assign out_rgba_b = rgba_b_ff;

endmodule

`default_nettype wire

/* hdl/cgev_mix.sv */
`default_nettype none

module cgev_mix
   import cgev_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  wire logic [FRAC_WIDTH-1:0] in_frac,
   input  wire logic [RGBA_WIDTH-1:0] in_rgba_a,
   input  wire logic [RGBA_WIDTH-1:0] in_rgba_b,
   output logic                       out_valid,
   output logic [RGBA_WIDTH-1:0]      out_rgba
);

   localparam int PW = 8 + FRAC_WIDTH;

   logic          prod_vld_ff;
   logic [PW-1:0] pa_ff [0:3];
   logic [PW-1:0] pb_ff [0:3];
   logic [FRAC_WIDTH-1:0] inv_frac;

   logic                  out_vld_ff;
   logic [RGBA_WIDTH-1:0] out_ff, out_in;

   assign inv_frac = FRAC_WIDTH'(18'h10000 - {1'b0, in_frac});

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else if (advance) begin
         prod_vld_ff <= in_valid;
      end
      if (advance) begin
         for (int c = 0; c < 4; c++) begin
            pa_ff[c] <= PW'(in_rgba_a[c*8 +: 8]) * PW'(inv_frac);
            pb_ff[c] <= PW'(in_rgba_b[c*8 +: 8]) * PW'(in_frac);
         end
      end
   end

   always_comb begin
      logic [PW:0] sum;
      out_in = '0;
      for (int c = 0; c < 4; c++) begin
         sum = {1'b0, pa_ff[c]} + {1'b0, pb_ff[c]} + (PW+1)'(32768);
         out_in[c*8 +: 8] = sum[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= prod_vld_ff;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_rgba  = out_ff;

endmodule

`default_nettype wire

/* hdl/cgev_checker.sv */
`default_nettype none

module cgev_checker
   import cgev_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [RGBA_WIDTH-1:0]     rsp_tdata,
   input wire logic                      csr_valid,
   input wire logic                      csr_ready
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // input never blocked when the output side is empty
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req blocked with empty output");

   // nothing leaves right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");

   // register writes are never stalled
   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write stalled");

endmodule

bind color_gradient_evaluate_top cgev_checker u_cgev_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

`default_nettype wire

/* sim/testbench.sv */
`default_nettype none

module testbench;
   import cgev_pkg::*;

   localparam int LIMIT_CYCLES = 300000;
   localparam int SETTLE_CYCLES = 50;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;   // sample_time, key_slot, key_position, key_rgba
   logic        req_tuser = 1'b0; // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // rgba_out
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = '0;

   color_gradient_evaluate_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // local copy of the ramp state
   logic [15:0] ramp_pos [8];
   logic [31:0] ramp_rgba [8];
   logic [3:0]  model_count = '0;
   logic [31:0] model_span = '0;

   logic [31:0] expected_colors [$];
   int          errors = 0;
   int          cycles = 0;
   int          burst_left = 0;
   int          evals_sent = 0;
   int          loads_sent = 0;
   int          colors_checked = 0;
   int          stall_mode = 0;

   function automatic logic [31:0] blend_color(logic [31:0] a, logic [31:0] b,
                                               longint unsigned f);
      logic [31:0]     mixed;
      longint unsigned c;
      mixed = '0;
      for (int ch = 0; ch < 4; ch++) begin
         c = (longint'(a[8*ch +: 8]) * (65536 - f) + longint'(b[8*ch +: 8]) * f + 32768)
             >> 16;
         mixed[8*ch +: 8] = c[7:0];
      end
      return mixed;
   endfunction

   function automatic longint unsigned scaled_time(logic [31:0] raw);
      longint t;
      t = longint'($signed(raw));
      if (model_span != 0) begin
         if (t <= 0) return 0;
         if (t >= longint'(model_span)) return 65535;
         return (t * 65535) / longint'(model_span);
      end
      if (t <= 0) return 0;
      if (t > 65536) t = 65536;
      return (t * 65535) >> 16;
   endfunction

   function automatic logic [31:0] ramp_color(logic [31:0] raw);
      int              n;
      longint unsigned tm, f, cur, prev;
      n = (model_count > 8) ? 8 : model_count;
      if (n == 0) return '0;
      if (n == 1) return ramp_rgba[0];
      tm = scaled_time(raw);
      if (tm < ramp_pos[0]) return ramp_rgba[0];
      for (int i = 1; i < n; i++) begin
         cur = ramp_pos[i];
         prev = ramp_pos[i-1];
         if (tm > cur) continue;
         f = 0;
         if (cur > prev && tm > prev) f = ((tm - prev) << 16) / (cur - prev);
         if (f > 65536) f = 65536;
         return blend_color(ramp_rgba[i-1], ramp_rgba[i], f);
      end
      return ramp_rgba[n-1];
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("mismatch %s: expected %08h got %08h at cycle %0d", what, want, got, cycles);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout at cycle %0d", cycles);
         $display("FAIL color_gradient_evaluate_top");
         $finish;
      end else if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_colors.size() == 0) begin
            report_mismatch("unexpected rgba_out", '0, rsp_tdata);
         end else begin
            if (rsp_tdata !== expected_colors[0])
               report_mismatch("rgba_out", expected_colors[0], rsp_tdata);
            void'(expected_colors.pop_front());
            colors_checked++;
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 4);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (cycles % 5 == 0);
         3: rsp_tready <= ($urandom_range(0, 9) != 0);
         default: rsp_tready <= (cycles % 16 < 8);
      endcase
   end

   task automatic send_item(op_type op, logic [31:0] sample_time, logic [2:0] slot,
                            logic [15:0] position, logic [31:0] rgba);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {5'b0, rgba, position, slot, sample_time};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_LOAD) begin
         ramp_pos[slot] = position;
         ramp_rgba[slot] = rgba;
         loads_sent++;
      end else begin
         expected_colors.push_back(ramp_color(sample_time));
         evals_sent++;
      end
   endtask

   task automatic evaluate_at(logic [31:0] sample_time);
      send_item(OP_EVALUATE, sample_time, 3'($urandom()), 16'($urandom()), $urandom());
   endtask

   task automatic load_key(logic [2:0] slot, logic [15:0] position, logic [31:0] rgba);
      send_item(OP_LOAD, $urandom(), slot, position, rgba);
   endtask

   // wait until every color has come back and the pipeline is empty
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type index, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == CSR_KEY_COUNT) model_count = value[3:0];
      else model_span = value;
   endtask

   task automatic set_ramp(logic [3:0] count, logic [31:0] span);
      drain_pipeline();
      write_csr(CSR_KEY_COUNT, {28'b0, count});
      write_csr(CSR_SPAN_LENGTH, span);
   endtask

   task automatic load_sorted_keys();
      logic [15:0] positions [8];
      logic [15:0] swap;
      for (int i = 0; i < 8; i++) positions[i] = 16'($urandom());
      if ($urandom_range(0, 3) == 0) positions[3] = positions[2];
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < 7 - i; j++)
            if (positions[j] > positions[j+1]) begin
               swap = positions[j];
               positions[j] = positions[j+1];
               positions[j+1] = swap;
            end
      for (int i = 0; i < 8; i++) load_key(3'(i), positions[i], $urandom());
   endtask

   task automatic test_empty_ramp();
      evaluate_at(32'h0000_8000);
      evaluate_at(32'h8000_0000);
   endtask

   task automatic test_directed();
      load_key(0, 16'h0000, 32'h0000_0000);
      load_key(1, 16'h4000, 32'hFFFF_FFFF);
      load_key(2, 16'h4000, 32'h1234_5678);
      load_key(3, 16'h3000, 32'h80FF_0180);
      load_key(4, 16'hFFFF, 32'hA5C3_5A3C);
      for (int i = 5; i < 8; i++) load_key(3'(i), 16'hFFFF, 32'h0F0F_F0F0);
      set_ramp(4'd8, 32'h0);
      evaluate_at(32'h8000_0000);
      evaluate_at(32'h0000_0000);
      evaluate_at(32'h0000_2000);
      evaluate_at(32'h0000_4000);
      evaluate_at(32'h0000_3800);
      evaluate_at(32'h0000_C000);
      evaluate_at(32'h0001_0000);
      evaluate_at(32'h7FFF_FFFF);
      set_ramp(4'd1, 32'hFFFF_FFFF);
      evaluate_at(32'h7FFF_FFFF);
      evaluate_at(32'hFFFF_FFFF);
      set_ramp(4'd15, 32'h0000_0001);
      evaluate_at(32'h0000_0001);
      evaluate_at(32'h0000_0000);
      set_ramp(4'd3, 32'h0003_0000);
      load_key(0, 16'h1000, 32'h00FF_00FF);
      evaluate_at(32'h0000_0100);
      evaluate_at(32'h0001_8000);
   endtask

   task automatic test_random(int phases, int items_per_phase);
      logic [3:0]  count;
      logic [31:0] span;
      logic [31:0] t;
      t = '0;
      for (int p = 0; p < phases; p++) begin
         drain_pipeline();
         load_sorted_keys();
         count = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(2, 8));
         case ($urandom_range(0, 3))
            0, 1: span = 32'h0;
            2: span = $urandom_range(1, 32'h0010_0000);
            default: span = $urandom();
         endcase
         set_ramp(count, span);
         for (int k = 0; k < items_per_phase; k++) begin
            case ($urandom_range(0, 9))
               0: t = $urandom();
               1: t = -$urandom_range(0, 32'h0002_0000);
               2: load_key(3'($urandom_range(0, 7)), 16'($urandom()), $urandom());
               default: t = (span == 0) ? $urandom_range(0, 32'h0001_0100)
                                        : $urandom_range(0, span);
            endcase
            if (k == items_per_phase / 2 && p == 1) drain_pipeline();
            evaluate_at(t);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_ramp();
      test_directed();
      test_random(8, 110);
      drain_pipeline();
      if (expected_colors.size() != 0) report_mismatch("missing rgba_out", '0, '0);
      $display("covered %0d evaluations and %0d key loads, %0d colors checked",
               evals_sent, loads_sent, colors_checked);
      $display("key counts 0..15, zero and nonzero spans, clamped and negative times");
      if (errors == 0) begin
         $display("PASS color_gradient_evaluate_top");
      end else begin
         $display("FAIL color_gradient_evaluate_top");
      end
      $finish;
   end

endmodule

`default_nettype wire
